/* rtl/pbra_pkg.sv */
// shared types and constants for the page bitmap run allocator
package pbra_pkg;

    localparam int PAGE_COUNT_DEF    = 128;
    localparam int INITIAL_PAGES_DEF = 4;
    localparam int PAGE_SHIFT        = 12;
    localparam int CNT_W             = 9;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [APB_ADDR_W-1:0] REG_BASE_ADDRESS = 3'd0;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_RELEASED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [19:0] size_bytes;
        logic [31:0] block_address;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] granted_address;
        logic [19:0] granted_bytes;
    } result_t;

endpackage

/* rtl/pbra_ram.sv */
// generic single write port ram with registered read
module pbra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/page_bitmap_run_allocator.sv */
// page bitmap run allocator: first-fit run search over a one-bit page map
//
// usage: an item is taken on a rising edge with start high and busy low.
// request.mode 0 allocates: the size becomes floor(size / 4096) + 1 pages
// (aligned sizes gain a page), raised to INITIAL_PAGES, and the map is
// scanned first-fit one page per cycle through the map ram's read port.
// a hit marks the run one page per cycle and returns base plus page offset;
// a miss or an oversized request returns no room. mode 1 releases whole
// pages from the page holding block_address, one page per cycle.
// each item gives exactly one result beat, shown on result for one cycle
// with done high; the receiver cannot stall it.
// allocate scans the map page by page until a run is found or the last
// page is checked, then marks one page per cycle; done rises in the cycle
// after the last page is marked.
// release stays busy while it clears pages; a release that clears nothing
// or an oversized allocate answers in the next cycle without raising busy.
// reset: base_address returns to 0 and a clearing pass writes every page of
// the map (first INITIAL_PAGES pages committed); busy is high meanwhile,
// apb writes are taken at any time.
module page_bitmap_run_allocator #(
    parameter int PAGE_COUNT    = pbra_pkg::PAGE_COUNT_DEF,
    parameter int INITIAL_PAGES = pbra_pkg::INITIAL_PAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pbra_pkg::request_t                  request,
    output logic                                done,
    output pbra_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbra_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pbra_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pbra_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PW    = $clog2(PAGE_COUNT);
    localparam int PTR_W = PW + 1;
    localparam int CW    = pbra_pkg::CNT_W;
    localparam int SH    = pbra_pkg::PAGE_SHIFT;
    localparam logic [PTR_W-1:0] LAST_PAGE = PTR_W'(PAGE_COUNT - 1);
    localparam logic [PTR_W-1:0] END_PAGE  = PTR_W'(PAGE_COUNT);
    localparam logic [PTR_W-1:0] INIT_PTR  = PTR_W'(INITIAL_PAGES);
    localparam logic [CW-1:0]    INIT_CNT  = CW'(INITIAL_PAGES);

    pbra_pkg::state_t  state_reg, state_next;
    pbra_pkg::result_t result_reg, result_next;
    logic              done_reg, done_next;
    logic [31:0]       base_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [PTR_W-1:0]  chk_ptr_reg, chk_ptr_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     need_reg, need_next;
    logic [CW-1:0]     run_reg, run_next;

    logic              ram_we;
    logic              ram_wdata;
    logic              ram_rdata;

    logic [CW-1:0]     req_pages;
    logic [CW-1:0]     req_need;
    logic [31:0]       rel_offset;
    logic [19:0]       rel_first;
    logic [CW-1:0]     rel_count;
    logic [CW-1:0]     run_inc;
    logic [PTR_W-1:0]  run_start;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr == pbra_pkg::REG_BASE_ADDRESS) ? base_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == pbra_pkg::REG_BASE_ADDRESS))
        begin
            base_reg <= pwdata;
        end
    end

    pbra_ram #(
        .WIDTH (1),
        .DEPTH (PAGE_COUNT)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg[PW-1:0]),
        .wdata (ram_wdata),
        .raddr (ptr_reg[PW-1:0]),
        .rdata (ram_rdata)
    );

    // request decode
    assign req_pages  = {1'b0, request.size_bytes[19:SH]} + CW'(1);
    assign req_need   = (req_pages < INIT_CNT) ? INIT_CNT : req_pages;
    assign rel_offset = request.block_address - base_reg;
    assign rel_first  = rel_offset[31:SH];
    assign rel_count  = {1'b0, request.size_bytes[19:SH]};

    assign run_inc    = run_reg + CW'(1);
    // first page of the run that ends at the page under check
    assign run_start  = chk_ptr_reg - PTR_W'(need_reg) + PTR_W'(1);

    assign busy   = (state_reg != pbra_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        done_next      = 1'b0;
        ptr_next       = ptr_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_valid_next = 1'b0;
        cnt_next       = cnt_reg;
        need_next      = need_reg;
        run_next       = run_reg;
        ram_we         = 1'b0;
        ram_wdata      = 1'b0;

        case (state_reg)
            pbra_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (ptr_reg < INIT_PTR);
                ptr_next  = ptr_reg + PTR_W'(1);
                if (ptr_reg == LAST_PAGE)
                begin
                    state_next = pbra_pkg::S_IDLE;
                end
            end

            pbra_pkg::S_IDLE:
            begin
                if (start)
                begin
                    result_next.granted_address = '0;
                    result_next.granted_bytes   = '0;
                    if (!request.mode)
                    begin
                        if (req_pages[CW-1])
                        begin
                            // rounded size does not fit the byte field
                            result_next.status = pbra_pkg::ST_NO_ROOM;
                            done_next          = 1'b1;
                        end
                        else
                        begin
                            need_next  = req_need;
                            ptr_next   = '0;
                            run_next   = '0;
                            state_next = pbra_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        result_next.status = pbra_pkg::ST_RELEASED;
                        if (({12'b0, rel_first} < 32'(PAGE_COUNT)) && (rel_count != '0))
                        begin
                            ptr_next   = PTR_W'(rel_first);
                            cnt_next   = rel_count;
                            state_next = pbra_pkg::S_FREE;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                end
            end

            pbra_pkg::S_SCAN:
            begin
                if (ptr_reg != END_PAGE)
                begin
                    ptr_next       = ptr_reg + PTR_W'(1);
                    chk_ptr_next   = ptr_reg;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg)
                begin
                    run_next = ram_rdata ? '0 : run_inc;
                    if (!ram_rdata && (run_inc == need_reg))
                    begin
                        ptr_next       = run_start;
                        cnt_next       = need_reg;
                        chk_valid_next = 1'b0;
                        result_next.status          = pbra_pkg::ST_GRANTED;
                        result_next.granted_address =
                            base_reg + (32'(run_start[PW-1:0]) << SH);
                        result_next.granted_bytes   = {need_reg[7:0], 12'b0};
                        state_next     = pbra_pkg::S_MARK;
                    end
                    else if (chk_ptr_reg == LAST_PAGE)
                    begin
                        result_next.status = pbra_pkg::ST_NO_ROOM;
                        done_next          = 1'b1;
                        state_next         = pbra_pkg::S_IDLE;
                    end
                end
            end

            pbra_pkg::S_MARK:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                ptr_next  = ptr_reg + PTR_W'(1);
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = pbra_pkg::S_IDLE;
                end
            end

            pbra_pkg::S_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b0;
                ptr_next  = ptr_reg + PTR_W'(1);
                cnt_next  = cnt_reg - CW'(1);
                // stop after the last requested page or at the last page of the map
                if ((cnt_reg == CW'(1)) || (ptr_reg == LAST_PAGE))
                begin
                    done_next  = 1'b1;
                    state_next = pbra_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pbra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbra_pkg::S_CLEAR;
            done_reg      <= 1'b0;
            ptr_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        chk_ptr_reg <= chk_ptr_next;
        cnt_reg     <= cnt_next;
        need_reg    <= need_next;
        run_reg     <= run_next;
    end

endmodule

/* dv/tb_page_bitmap_run_allocator.sv */
// testbench for the page bitmap run allocator: first-fit prediction and result checking
`timescale 1ns / 1ps

class alloc_scoreboard;
    bit [pbra_pkg::PAGE_COUNT_DEF-1:0] committed;
    logic [31:0]                       base_address;
    pbra_pkg::result_t                 pending_results[$];
    int                                mismatches;

    function new();
        committed = '0;
        for (int p = 0; p < pbra_pkg::INITIAL_PAGES_DEF; p++)
            committed[p] = 1'b1;
        base_address = '0;
        mismatches   = 0;
    endfunction

    function void set_base(logic [31:0] value);
        base_address = value;
    endfunction

    // updates the page map for one accepted request and queues its expected beat
    function pbra_pkg::result_t note_request(pbra_pkg::request_t req);
        pbra_pkg::result_t res;
        logic [31:0]       rounded;
        logic [31:0]       offset;
        logic [31:0]       first;
        int                need;
        int                count;
        int                run;
        int                p;
        int                k;
        bit                placed;
        res = '0;
        if (req.mode == 1'b0)
        begin
            res.status = pbra_pkg::ST_NO_ROOM;
            rounded = ({12'd0, req.size_bytes} + 32'd4096) & 32'hFFFF_F000;
            if (rounded < pbra_pkg::INITIAL_PAGES_DEF * (1 << pbra_pkg::PAGE_SHIFT))
                rounded = pbra_pkg::INITIAL_PAGES_DEF * (1 << pbra_pkg::PAGE_SHIFT);
            need   = rounded >> pbra_pkg::PAGE_SHIFT;
            placed = 1'b0;
            p      = 0;
            // oversized grants never reach the search
            if (rounded > 32'h000F_FFFF)
                placed = 1'b1;
            while (!placed && p < pbra_pkg::PAGE_COUNT_DEF)
            begin
                if (!committed[p])
                begin
                    run = 0;
                    while (p + run < pbra_pkg::PAGE_COUNT_DEF && !committed[p + run])
                        run++;
                    if (run >= need)
                    begin
                        for (k = 0; k < need; k++)
                            committed[p + k] = 1'b1;
                        placed              = 1'b1;
                        res.status          = pbra_pkg::ST_GRANTED;
                        res.granted_address = base_address + (p << pbra_pkg::PAGE_SHIFT);
                        res.granted_bytes   = rounded[19:0];
                    end
                end
                p++;
            end
        end
        else
        begin
            res.status = pbra_pkg::ST_RELEASED;
            offset = req.block_address - base_address;
            first  = offset >> pbra_pkg::PAGE_SHIFT;
            count  = int'(req.size_bytes >> pbra_pkg::PAGE_SHIFT);
            k      = 0;
            while (k < count && first + k < pbra_pkg::PAGE_COUNT_DEF)
            begin
                committed[first + k] = 1'b0;
                k++;
            end
        end
        pending_results.push_back(res);
        return res;
    endfunction

    function void check_result(pbra_pkg::result_t got);
        pbra_pkg::result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result beat with no request outstanding: status %0d address %h",
                   got.status, got.granted_address);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.granted_address !== want.granted_address)
            begin
                $error("granted_address: expected %h, got %h",
                       want.granted_address, got.granted_address);
                mismatches++;
            end
            if (got.granted_bytes !== want.granted_bytes)
            begin
                $error("granted_bytes: expected %h, got %h",
                       want.granted_bytes, got.granted_bytes);
                mismatches++;
            end
        end
    endfunction
endclass

module tb_page_bitmap_run_allocator;
    import pbra_pkg::*;

    localparam int   PAGE_BYTES      = 1 << PAGE_SHIFT;
    localparam int   ITEMS_PER_PHASE = 190;
    localparam int   CYCLE_LIMIT     = 2_000_000;
    localparam int   DRAIN_CYCLES    = 300;
    localparam logic MODE_ALLOC      = 1'b0;
    localparam logic MODE_RELEASE    = 1'b1;

    typedef struct {
        int          page;
        logic [19:0] bytes;
    } live_run_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    request_t              request = '0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic                  busy;
    logic                  done;
    result_t               result;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    alloc_scoreboard sb = new();
    live_run_t       live_runs[$];
    int              burst_left = 0;

    page_bitmap_run_allocator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_page_bitmap_run_allocator: done, errors");
        $finish;
    end

    task automatic write_base(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_BASE_ADDRESS;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_base(value);
    endtask

    // holds start until busy is low, then notes the request and tracks any granted run
    task automatic send_item(request_t req);
        result_t   want;
        live_run_t run;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy) @(posedge clk);
        want = sb.note_request(req);
        if (req.mode == MODE_ALLOC && want.status == ST_GRANTED)
        begin
            run.page  = (want.granted_address - sb.base_address) >> PAGE_SHIFT;
            run.bytes = want.granted_bytes;
            live_runs.push_back(run);
        end
    endtask

    task automatic idle_gap();
        int n;
        int r;
        n = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                burst_left = $urandom_range(10, 40);
            else if (r < 55)
                n = 0;
            else if (r < 85)
                n = $urandom_range(1, 3);
            else if (r < 97)
                n = $urandom_range(4, 12);
            else
                n = $urandom_range(20, 60);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic request_t make_req(logic mode, logic [19:0] size, logic [31:0] addr);
        request_t req;
        req.mode          = mode;
        req.size_bytes    = size;
        req.block_address = addr;
        return req;
    endfunction

    task automatic run_directed();
        logic [31:0] b;
        request_t    reqs[$];
        b = sb.base_address;
        reqs.push_back(make_req(MODE_ALLOC, 20'd0, 32'd0));
        reqs.push_back(make_req(MODE_ALLOC, 20'd4096, 32'd0));
        reqs.push_back(make_req(MODE_ALLOC, 20'd16384, 32'd0));
        // rounds past the 20-bit field, then too many pages, then exactly the whole map
        reqs.push_back(make_req(MODE_ALLOC, 20'hFFFFF, 32'hFFFF_FFFF));
        reqs.push_back(make_req(MODE_ALLOC, 20'hFEFFF, 32'd0));
        reqs.push_back(make_req(MODE_ALLOC, 20'h7F000, 32'd0));
        reqs.push_back(make_req(MODE_RELEASE, 20'd4095, b + 4 * PAGE_BYTES));
        reqs.push_back(make_req(MODE_RELEASE, 20'(8 * PAGE_BYTES), b + 100 * PAGE_BYTES));
        reqs.push_back(make_req(MODE_RELEASE, 20'd4096, b + 200 * PAGE_BYTES));
        reqs.push_back(make_req(MODE_RELEASE, 20'hFFFFF, b - PAGE_BYTES));
        reqs.push_back(make_req(MODE_RELEASE, 20'(4 * PAGE_BYTES),
                                b + 8 * PAGE_BYTES + 'hABC));
        reqs.push_back(make_req(MODE_ALLOC, 20'd4095, 32'd0));
        reqs.push_back(make_req(MODE_RELEASE, 20'(4 * PAGE_BYTES), b));
        reqs.push_back(make_req(MODE_ALLOC, 20'd100, 32'd0));
        reqs.push_back(make_req(MODE_RELEASE, 20'(8 * PAGE_BYTES), b + 124 * PAGE_BYTES));
        reqs.push_back(make_req(MODE_RELEASE, 20'hFFFFF, b));
        reqs.push_back(make_req(MODE_ALLOC, 20'h7EFFF, 32'd0));
        reqs.push_back(make_req(MODE_ALLOC, 20'd0, 32'd0));
        reqs.push_back(make_req(MODE_RELEASE, 20'h80000, b));
        reqs.push_back(make_req(MODE_ALLOC, 20'h7F000 - 20'd1, 32'd0));
        reqs.push_back(make_req(MODE_RELEASE, 20'h80000, b));
        reqs.push_back(make_req(MODE_ALLOC, 20'd0, 32'hFFFF_FFFF));
        reqs.push_back(make_req(MODE_RELEASE, 20'd0, 32'hFFFF_FFFF));
        reqs.push_back(make_req(MODE_RELEASE, 20'hFFFFF, b));
        foreach (reqs[i])
        begin
            send_item(reqs[i]);
            idle_gap();
        end
        live_runs.delete();
    endtask

    // mostly allocations and matching releases of live runs, with some stray releases
    task automatic make_random_req(output request_t req);
        int        pick;
        int        r;
        int        idx;
        live_run_t run;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        req.block_address = $urandom();
        if (pick < 40 && live_runs.size() > 0)
        begin
            idx = $urandom_range(0, live_runs.size() - 1);
            run = live_runs[idx];
            live_runs.delete(idx);
            req.mode          = MODE_RELEASE;
            req.block_address = sb.base_address + run.page * PAGE_BYTES;
            if ($urandom_range(0, 1))
                req.block_address = req.block_address + $urandom_range(0, PAGE_BYTES - 1);
            if (r < 80)
                req.size_bytes = run.bytes;
            else if (r < 90)
                req.size_bytes = 20'(run.bytes + $urandom_range(0, PAGE_BYTES - 1));
            else
                req.size_bytes = 20'($urandom_range(0, run.bytes));
        end
        else if (pick < 88)
        begin
            req.mode = MODE_ALLOC;
            if (r < 60)
                req.size_bytes = 20'($urandom_range(0, 7 * PAGE_BYTES));
            else if (r < 75)
                req.size_bytes = 20'($urandom_range(0, 8) * PAGE_BYTES);
            else if (r < 92)
                req.size_bytes = 20'($urandom_range(0, 40 * PAGE_BYTES));
            else
                req.size_bytes = 20'($urandom());
        end
        else
        begin
            req.mode = MODE_RELEASE;
            if (r < 50)
            begin
                req.size_bytes = 20'($urandom());
            end
            else if (r < 80)
            begin
                req.block_address = sb.base_address
                                  + $urandom_range(0, PAGE_COUNT_DEF + 8) * PAGE_BYTES
                                  + $urandom_range(0, PAGE_BYTES - 1);
                req.size_bytes    = 20'($urandom_range(0, 3 * PAGE_BYTES));
            end
            else
            begin
                req.size_bytes = '0;
            end
        end
    endtask

    initial
    begin
        logic [31:0] bases[6];
        request_t    req;
        bases[0] = 32'h0004_0000;
        bases[1] = 32'h0000_0000;
        bases[2] = 32'hFFFF_F000;
        bases[3] = 32'hFFFF_FFFF;
        bases[4] = $urandom() & 32'hFFFF_F000;
        bases[5] = $urandom();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (bases[ph])
        begin
            if (ph > 0)
                wait_for_results();
            write_base(bases[ph]);
            if (ph == 0)
                run_directed();
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                make_random_req(req);
                send_item(req);
                if ($urandom_range(0, 99) == 0)
                    wait_for_results();
                else
                    idle_gap();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_page_bitmap_run_allocator: done, clean");
        else
            $display("tb_page_bitmap_run_allocator: done, errors");
        $finish;
    end

endmodule
